/* rtl/integer_literal_scanner_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the integer literal scanner
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_SCANNER_MACROS_SVH
`define INTEGER_LITERAL_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ILS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_literal_scanner: same-cycle check failed");
// next-cycle implication
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_literal_scanner: next-cycle check failed");
`else
`define ILS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Types, character codes and helper functions for the integer literal scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  localparam int VALUE_BITS = 64;
  // value * 16 + 15 fits in four extra bits
  localparam int PROD_W     = VALUE_BITS + 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_O  = 8'h6f;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;
  localparam logic [1:0] RADIX_OCT = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [4:0] NOT_HEX = 5'd16;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_ZERO    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_SWALLOW = 4'b1000
  } scan_phase_t;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] char_in;
  } ils_in_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [1:0]  radix_code;
    logic [1:0]  status_out;
    logic [15:0] consumed_len;
  } ils_out_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = 5'(c - CH_LO_A) + 5'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = 5'(c - CH_UP_A) + 5'd10;
    end else begin
      d = NOT_HEX;
    end
    return d;
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [4:0] base_of(input logic [1:0] radix);
    logic [4:0] b;
    case (radix)
      RADIX_DEC: b = 5'd10;
      RADIX_HEX: b = 5'd16;
      RADIX_BIN: b = 5'd2;
      RADIX_OCT: b = 5'd8;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/integer_literal_scanner.sv */
// ----------------------------------------------------------------------------
// integer_literal_scanner
// Scans an integer literal one byte per transfer (0x/0X, 0b/0B, 0o prefixes,
// underscores skipped) and returns value, radix, status and length when the
// first unconsumed byte arrives.
//
//   channel | direction | ports                              | payload
//   in      | input     | in_valid, in_ready, in_data        | ils_in_t
//   out     | output    | out_valid, out_ready, out_data     | ils_out_t
//
// One byte per cycle sustained while no result is held: a byte is registered in
// the byte stage, then the scan state and the result register are updated from it.
// out_valid rises once the terminating byte has left the byte stage and the result register is loaded.
// The per-byte path is one multiply-by-constant (shift/add) and overflow check.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A held result stalls the byte stage only while out_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_literal_scanner_macros.svh"

module integer_literal_scanner (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire ils_pkg::ils_in_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output ils_pkg::ils_out_t out_data
);
  import ils_pkg::*;

  // byte stage
  logic    st_vld_r;
  ils_in_t st_data_r;

  // scan state
  scan_phase_t            phase_r, phase_nxt;
  logic [1:0]             radix_r, radix_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [1:0]             err_r, err_nxt;
  logic [15:0]            len_r, len_nxt;

  // result stage
  logic     out_vld_r;
  ils_out_t out_data_r, out_data_nxt;
  logic     emit;

  logic adv;
  logic do_digit;
  logic [4:0] d;
  logic [PROD_W-1:0] acc_ext, prod;
  logic overflow;
  logic [7:0] c;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !st_vld_r || adv;
  assign c        = st_data_r.char_in;
  assign d        = hex_value(c);

  always_comb begin
    phase_nxt    = phase_r;
    radix_nxt    = radix_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    len_nxt      = len_r;
    emit         = 1'b0;
    do_digit     = 1'b0;
    acc_ext      = '0;
    prod         = '0;
    overflow     = 1'b0;

    if (st_data_r.first_byte) begin
      radix_nxt = RADIX_DEC;
      acc_nxt   = '0;
      err_nxt   = STAT_OK;
      len_nxt   = '0;
      if (c == CH_ZERO) begin
        len_nxt   = 16'd1;
        phase_nxt = PH_ZERO;
      end else begin
        phase_nxt = PH_DIGITS;
        do_digit  = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_ZERO: begin
          phase_nxt = PH_DIGITS;
          if (c == CH_LO_X || c == CH_UP_X) begin
            radix_nxt = RADIX_HEX;
            len_nxt   = 16'd2;
          end else if (c == CH_LO_B || c == CH_UP_B) begin
            radix_nxt = RADIX_BIN;
            len_nxt   = 16'd2;
          end else if (c == CH_LO_O) begin
            radix_nxt = RADIX_OCT;
            len_nxt   = 16'd2;
          end else begin
            // the leading zero was a decimal digit
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        PH_SWALLOW: begin
          if (is_decimal(c)) begin
            len_nxt = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            emit      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (do_digit) begin
      acc_ext = PROD_W'(acc_nxt);
      case (radix_nxt)
        RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
        RADIX_HEX: prod = acc_ext << 4;
        RADIX_BIN: prod = acc_ext << 1;
        RADIX_OCT: prod = acc_ext << 3;
        default:   prod = acc_ext;
      endcase
      prod     = prod + PROD_W'(d);
      overflow = |prod[PROD_W-1:VALUE_BITS];

      if (c == CH_UNDER) begin
        len_nxt = (len_nxt == 16'hFFFF) ? len_nxt : len_nxt + 16'd1;
      end else if (d == NOT_HEX) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end else if (d >= base_of(radix_nxt) || overflow) begin
        err_nxt = (d >= base_of(radix_nxt)) ? STAT_RANGE : STAT_OVERFLOW;
        acc_nxt = '0;
        if (is_decimal(c)) begin
          len_nxt   = (len_nxt == 16'hFFFF) ? len_nxt : len_nxt + 16'd1;
          phase_nxt = PH_SWALLOW;
        end else begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end else begin
        acc_nxt = prod[VALUE_BITS-1:0];
        len_nxt = (len_nxt == 16'hFFFF) ? len_nxt : len_nxt + 16'd1;
      end
    end

    out_data_nxt.value_out    = (err_nxt != STAT_OK) ? 64'd0 : 64'(acc_nxt);
    out_data_nxt.radix_code   = radix_nxt;
    out_data_nxt.status_out   = err_nxt;
    out_data_nxt.consumed_len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else if (in_ready) begin
      st_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      st_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      radix_r <= RADIX_DEC;
      acc_r   <= '0;
      err_r   <= STAT_OK;
      len_r   <= '0;
    end else if (st_vld_r && adv) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      err_r   <= err_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (st_vld_r && adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (st_vld_r && adv && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // an errored result never carries a value
  `ILS_ASSERT_NOW(a_err_value_zero, clk, rst_n,
    out_vld_r && (out_data_r.status_out != STAT_OK), out_data_r.value_out == 64'd0)
  // swallowing only happens after an error, with the value cleared
  `ILS_ASSERT_NOW(a_swallow_err, clk, rst_n,
    phase_r == PH_SWALLOW, (err_r != STAT_OK) && (acc_r == '0))
  // a prefixed literal has consumed at least its two prefix bytes
  `ILS_ASSERT_NOW(a_prefix_len, clk, rst_n,
    out_vld_r && (out_data_r.radix_code != RADIX_DEC), out_data_r.consumed_len >= 16'd2)
  // after a leading zero the state is a fresh decimal literal of length one
  `ILS_ASSERT_NOW(a_zero_phase, clk, rst_n,
    phase_r == PH_ZERO, (len_r == 16'd1) && (radix_r == RADIX_DEC) && (acc_r == '0))
  // a stalled result holds the byte stage
  `ILS_ASSERT_NEXT(a_stage_hold, clk, rst_n,
    st_vld_r && out_vld_r && !out_ready, st_vld_r && $stable(st_data_r))

endmodule

`default_nettype wire

/* verif/tb_integer_literal_scanner.sv */
// ----------------------------------------------------------------------------
// tb_integer_literal_scanner
// Self-checking bench for the integer literal scanner. A byte-level scan model
// predicts each literal result. A short table of directed bytes comes first,
// then random literals (prefixed, max and overflowing values, range errors,
// restarts, noise) under four idle/stall mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_literal_scanner;
  import ils_pkg::*;

  // No-transfer cycles before giving up. The longest correct gap is the
  // receiver hold-off plus a sender idle run.
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int BYTES_PER_MIX = 500;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ils_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ils_out_t out_data;

  integer_literal_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // scan model state
  scan_phase_t scan_state = PH_IDLE;
  logic [1:0]  lit_radix  = RADIX_DEC;
  logic [63:0] lit_value  = '0;
  logic [1:0]  lit_status = STAT_OK;
  logic [15:0] lit_len    = '0;

  ils_out_t   lit_expect[$];
  logic [7:0] lit_bytes[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  int          bytes_sent = 0;

  int errors = 0;
  int results_seen = 0;
  int range_seen = 0;
  int ovf_seen = 0;
  int radix_seen[4] = '{0, 0, 0, 0};

  typedef struct {
    logic       fb;
    logic [7:0] ch;
    bit         has_want;
    ils_out_t   want;
  } dir_row_t;

  dir_row_t dir_rows[26];

  function automatic void count_one();
    if (lit_len != 16'hFFFF) lit_len++;
  endfunction

  function automatic ils_out_t close_literal();
    ils_out_t r;
    r.value_out    = (lit_status == STAT_OK) ? lit_value : 64'd0;
    r.radix_code   = lit_radix;
    r.status_out   = lit_status;
    r.consumed_len = lit_len;
    scan_state = PH_IDLE;
    return r;
  endfunction

  // Advances the scan model by one byte; returns 1 when the byte ends a literal.
  function automatic bit scan_byte(input logic fb, input logic [7:0] ch,
                                   output ils_out_t res);
    logic [63:0] base;
    logic [63:0] dig;
    logic [63:0] max_val;
    bit          is_dec;
    res     = '0;
    max_val = 64'({VALUE_BITS{1'b1}});
    is_dec  = ch inside {[CH_ZERO:CH_NINE]};
    if (fb) begin
      lit_radix  = RADIX_DEC;
      lit_value  = '0;
      lit_status = STAT_OK;
      lit_len    = '0;
      if (ch == CH_ZERO) begin
        lit_len    = 16'd1;
        scan_state = PH_ZERO;
        return 1'b0;
      end
      scan_state = PH_DIGITS;
    end else if (scan_state == PH_IDLE) begin
      return 1'b0;
    end else if (scan_state == PH_ZERO) begin
      case (ch)
        CH_LO_X, CH_UP_X: lit_radix = RADIX_HEX;
        CH_LO_B, CH_UP_B: lit_radix = RADIX_BIN;
        CH_LO_O:          lit_radix = RADIX_OCT;
        default:          lit_radix = RADIX_DEC;
      endcase
      scan_state = PH_DIGITS;
      if (lit_radix != RADIX_DEC) begin
        lit_len = 16'd2;
        return 1'b0;
      end
      // no prefix: the leading zero stands as digit 0, this byte goes on below
    end

    if (scan_state == PH_SWALLOW) begin
      if (is_dec) begin
        count_one();
        return 1'b0;
      end
      res = close_literal();
      return 1'b1;
    end

    if (ch == CH_UNDER) begin
      count_one();
      return 1'b0;
    end
    if (is_dec) begin
      dig = 64'(ch - CH_ZERO);
    end else if (ch inside {[CH_LO_A:CH_LO_F]}) begin
      dig = 64'(ch - CH_LO_A) + 64'd10;
    end else if (ch inside {[CH_UP_A:CH_UP_F]}) begin
      dig = 64'(ch - CH_UP_A) + 64'd10;
    end else begin
      res = close_literal();
      return 1'b1;
    end
    case (lit_radix)
      RADIX_HEX: base = 64'd16;
      RADIX_BIN: base = 64'd2;
      RADIX_OCT: base = 64'd8;
      default:   base = 64'd10;
    endcase
    if (dig >= base) begin
      lit_status = STAT_RANGE;
    end else if (lit_value > (max_val - dig) / base) begin
      lit_status = STAT_OVERFLOW;
    end else begin
      lit_value = lit_value * base + dig;
      count_one();
      return 1'b0;
    end
    lit_value = '0;
    // a decimal digit after an error is eaten, a letter ends the literal
    if (is_dec) begin
      count_one();
      scan_state = PH_SWALLOW;
      return 1'b0;
    end
    res = close_literal();
    return 1'b1;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v, input bit upper);
    if (v < 10) return CH_ZERO + 8'(v);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) lit_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] stop_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'h20;
      2:       return 8'h3b;
      3:       return 8'h29;
      4:       return 8'h67;
      5:       return 8'h2e;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One byte transfer; the expectation is queued before the byte goes out.
  task automatic send_byte(input logic fb, input logic [7:0] ch,
                           input bit has_want, input ils_out_t want);
    ils_out_t res;
    bit       ends;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    ends = scan_byte(fb, ch, res);
    if (has_want) lit_expect.push_back(want);
    else if (ends) lit_expect.push_back(res);
    in_valid <= 1'b1;
    in_data  <= '{first_byte: fb, char_in: ch};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_random_literal();
    int unsigned style;
    int unsigned nd;
    int unsigned base_n;
    int unsigned pick;
    style = $urandom_range(99);
    lit_bytes.delete();
    if (style < 8) begin
      // noise: stray bytes, either marking
      repeat ($urandom_range(1, 4)) send_byte(1'($urandom_range(1)),
                                              8'($urandom_range(255)), 1'b0, '0);
      return;
    end
    if (style < 14) begin
      case ($urandom_range(4))
        0: push_text("0xFFFFFFFFFFFFFFFF");
        1: push_text("0Xffff_FFFF_ffff_FFFF");
        2: push_text("0xfffffffffffffffff");
        3: push_text("18446744073709551615");
        default: begin
          push_text("18446744073709551616");
          repeat ($urandom_range(3))
            lit_bytes.push_back(digit_char($urandom_range(9), 1'b0));
        end
      endcase
    end else begin
      pick = $urandom_range(3);
      case (pick)
        1: begin
          base_n = 16;
          lit_bytes.push_back(CH_ZERO);
          lit_bytes.push_back($urandom_range(1) ? CH_UP_X : CH_LO_X);
        end
        2: begin
          base_n = 2;
          lit_bytes.push_back(CH_ZERO);
          lit_bytes.push_back($urandom_range(1) ? CH_UP_B : CH_LO_B);
        end
        3: begin
          base_n = 8;
          lit_bytes.push_back(CH_ZERO);
          lit_bytes.push_back(CH_LO_O);
        end
        default: begin
          base_n = 10;
          if ($urandom_range(4) == 0) lit_bytes.push_back(CH_ZERO);
        end
      endcase
      nd = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      repeat (nd) begin
        if ($urandom_range(9) == 0) lit_bytes.push_back(CH_UNDER);
        if ($urandom_range(19) == 0) begin
          lit_bytes.push_back(digit_char($urandom_range(15), 1'($urandom_range(1))));
        end else begin
          lit_bytes.push_back(digit_char($urandom_range(base_n - 1),
                                         1'($urandom_range(1))));
        end
      end
    end
    // now and then leave the literal open so the next one restarts it
    if ($urandom_range(19) != 0) lit_bytes.push_back(stop_byte());
    foreach (lit_bytes[i]) send_byte(i == 0, lit_bytes[i], 1'b0, '0);
  endtask

  // result check and receiver ready
  ils_out_t want_res;
  bit       bad_field;
  int       hold_left = 0;
  bit       hold_used = 1'b0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      radix_seen[out_data.radix_code]++;
      if (out_data.status_out == STAT_RANGE) range_seen++;
      if (out_data.status_out == STAT_OVERFLOW) ovf_seen++;
      if (lit_expect.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: unexpected result value=%h radix=%0d status=%0d len=%0d",
                   out_data.value_out, out_data.radix_code, out_data.status_out,
                   out_data.consumed_len);
        end
      end else begin
        want_res  = lit_expect.pop_front();
        bad_field = (out_data.value_out !== want_res.value_out) ||
                    (out_data.radix_code !== want_res.radix_code) ||
                    (out_data.status_out !== want_res.status_out) ||
                    (out_data.consumed_len !== want_res.consumed_len);
        if (bad_field) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: result %0d exp value=%h radix=%0d status=%0d len=%0d",
                     results_seen, want_res.value_out, want_res.radix_code,
                     want_res.status_out, want_res.consumed_len);
            $display("       got value=%h radix=%0d status=%0d len=%0d",
                     out_data.value_out, out_data.radix_code, out_data.status_out,
                     out_data.consumed_len);
          end
        end
      end
    end
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int start_cnt;
    dir_rows = '{
      '{1'b0, 8'hFF,    1'b0, '0},                                    // idle, ignored
      '{1'b1, 8'h00,    1'b1, '{64'd0, RADIX_DEC, STAT_OK, 16'd0}},   // end of text first
      '{1'b1, CH_LO_A,  1'b1, '{64'd0, RADIX_DEC, STAT_RANGE, 16'd0}},
      '{1'b1, CH_ZERO,  1'b0, '0},
      '{1'b0, CH_LO_X,  1'b0, '0},
      '{1'b0, 8'hFF,    1'b1, '{64'd0, RADIX_HEX, STAT_OK, 16'd2}},   // prefix, no digits
      '{1'b1, CH_ZERO,  1'b0, '0},
      '{1'b0, CH_LO_B,  1'b0, '0},
      '{1'b0, 8'h31,    1'b0, '0},
      '{1'b0, 8'h32,    1'b0, '0},                                    // too big for base 2
      '{1'b0, CH_UNDER, 1'b1, '{64'd0, RADIX_BIN, STAT_RANGE, 16'd4}},
      '{1'b1, CH_ZERO,  1'b0, '0},
      '{1'b0, CH_LO_O,  1'b0, '0},
      '{1'b0, 8'h37,    1'b0, '0},
      '{1'b0, 8'h38,    1'b0, '0},
      '{1'b0, CH_NINE,  1'b0, '0},                                    // swallowed
      '{1'b0, 8'h7a,    1'b1, '{64'd0, RADIX_OCT, STAT_RANGE, 16'd5}},
      '{1'b1, CH_ZERO,  1'b0, '0},
      '{1'b0, CH_UP_B,  1'b0, '0},
      '{1'b1, CH_ZERO,  1'b0, '0},                                    // restart drops 0B
      '{1'b0, CH_UP_X,  1'b0, '0},
      '{1'b0, CH_UP_A,  1'b0, '0},
      '{1'b0, 8'h67,    1'b0, '0},
      '{1'b1, CH_ZERO,  1'b0, '0},
      '{1'b0, 8'h35,    1'b0, '0},                                    // leading zero as digit
      '{1'b0, 8'h00,    1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].fb, dir_rows[i].ch, dir_rows[i].has_want, dir_rows[i].want);
    end

    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // long receiver hold-off so the scanner backs up into its input
      if (mix == 0) hold_go = 1'b1;
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < BYTES_PER_MIX) send_random_literal();
    end
    in_valid <= 1'b0;

    while (lit_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes over four idle/stall mixes; checked %0d literals", bytes_sent,
             results_seen);
    $display("  (%0d range errors, %0d overflows; dec/hex/bin/oct %0d/%0d/%0d/%0d)",
             range_seen, ovf_seen, radix_seen[0], radix_seen[1], radix_seen[2],
             radix_seen[3]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ils_pkg.sv
rtl/integer_literal_scanner.sv
verif/tb_integer_literal_scanner.sv
